// ===== rtl/core/abbd2x_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package abbd2x_pkg;

  // register map
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BG_COLOR     = 2'd2,
    REG_BAKE_ENABLE  = 2'd3
  } cfg_reg_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned ROW_LIMIT  = 4096;
  localparam int unsigned PAIR_W     = 36;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd1;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd1;
  localparam logic [31:0]       BG_RST     = 32'hFF40_4040;
  localparam logic [7:0]        CH_MAX     = 8'hFF;

  typedef logic [31:0]       argb_t;
  typedef logic [PAIR_W-1:0] pair_t;

  // position flags of one word, carried down the pipe
  typedef struct packed {
    logic col_odd;
    logic row_odd;
    logic last_col;
    logic last_row;
  } pos_t;

  // c + floor(bg_c * (255 - a) / 255), saturated, on all four channels
  function automatic argb_t bake_px(input argb_t px, input argb_t bg);
    argb_t       res;
    logic [7:0]  inv;
    logic [15:0] prod;
    logic [16:0] acc;
    logic [7:0]  quo;
    logic [8:0]  sum;
    begin
      res = '0;
      inv = CH_MAX - px[31:24];
      for (int k = 0; k < 4; k++) begin
        prod = bg[8*k +: 8] * inv;
        // exact floor division by 255 for the 8x8-bit product
        acc  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
        quo  = acc[15:8];
        sum  = {1'b0, px[8*k +: 8]} + {1'b0, quo};
        res[8*k +: 8] = sum[8] ? CH_MAX : sum[7:0];
      end
      return res;
    end
  endfunction

  // per-channel 9-bit sums of two pixels
  function automatic pair_t pair_sum(input argb_t p, input argb_t q);
    pair_t s;
    begin
      s = '0;
      for (int k = 0; k < 4; k++) begin
        s[9*k +: 9] = {1'b0, p[8*k +: 8]} + {1'b0, q[8*k +: 8]};
      end
      return s;
    end
  endfunction

  // floor of the four-pixel sum over 4
  function automatic argb_t box_avg(input pair_t top, input pair_t bot);
    argb_t      res;
    logic [9:0] s;
    begin
      res = '0;
      for (int k = 0; k < 4; k++) begin
        s = {1'b0, top[9*k +: 9]} + {1'b0, bot[9*k +: 9]};
        res[8*k +: 8] = s[9:2];
      end
      return res;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/alpha_bake_box_downsample_2x_core.sv =====
// Background baking and 2x2 box downsampler.
// Input channel: one ARGB8888 source word per in_valid/in_ready handshake,
// raster order, frame size from the cfg_ registers. Every input word gives
// exactly one output word: the baked pixel, plus a half-resolution pixel
// with down_valid set when the word completes a 2x2 block (down_last marks
// the final one of the frame). Odd right/bottom edges pad with the
// background colour.
// Each word passes the input stage, bake stage and output register. Throughput
// without stalls: one word per cycle, set by the simple dual-port line store (one
// read and one write per cycle, previous write forwarded on an index match).
// The pipe (input stage, bake stage, output register) advances as a whole
// whenever the output register is empty or being taken; a receiver stall
// freezes it and drops in_ready, holding all words in place.
// Reset (synchronous, rst_n low) clears the counters, pipe valids and
// registers to width 1, height 1, background 0xFF404040, baking on. The
// line store is not cleared: an odd row only reads entries its even row
// wrote. Configuration may be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module alpha_bake_box_downsample_2x_core
  import abbd2x_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned LINE_DEPTH = 2048
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // configuration
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  // source words
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire [31:0]            in_pixel_in,
  // result words
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [31:0]           out_baked_pixel,
  output logic                  out_down_valid,
  output logic [31:0]           out_down_pixel,
  output logic                  out_down_last
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned CMP_W  = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;
  localparam int unsigned IDX_W  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LINE_DEPTH - 1);
  localparam logic [CMP_W-1:0] MAXW_C   = CMP_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] ROWL_C  = SIZE_W'(ROW_LIMIT);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0] width_r, height_r;
  argb_t             bg_r;
  logic              bake_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      bg_r      <= BG_RST;
      bake_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_r   <= cfg_wdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: height_r  <= cfg_wdata[SIZE_W-1:0];
        REG_BG_COLOR:     bg_r      <= cfg_wdata;
        REG_BAKE_ENABLE:  bake_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // pipe control: whole pipe moves when the output register frees up
  // ---------------------------------------------------------------------
  logic out_valid_r;
  logic adv;
  logic accept;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  // ---------------------------------------------------------------------
  // position counters (advance on accept)
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [CMP_W-1:0]  w_nz, w_eff, col_p1;
  logic [SIZE_W-1:0] h_nz, h_eff, row_p1;
  pos_t              pos_now;

  always_comb begin
    w_nz   = (width_r == '0) ? CMP_W'(1) : CMP_W'(width_r);
    w_eff  = (w_nz > MAXW_C) ? MAXW_C : w_nz;
    h_nz   = (height_r == '0) ? SIZE_W'(1) : height_r;
    h_eff  = (h_nz > ROWL_C) ? ROWL_C : h_nz;
    col_p1 = CMP_W'(col_r) + CMP_W'(1);
    row_p1 = SIZE_W'(row_r) + SIZE_W'(1);

    pos_now.col_odd  = col_r[0];
    pos_now.row_odd  = row_r[0];
    pos_now.last_col = (col_p1 >= w_eff);
    pos_now.last_row = (row_p1 >= h_eff);

    if (pos_now.last_col) begin
      col_nxt = '0;
      idx_nxt = '0;
      row_nxt = pos_now.last_row ? '0 : row_p1[ROW_W-1:0];
    end else begin
      col_nxt = col_p1[COL_W-1:0];
      row_nxt = row_r;
      // line index tracks col/2 modulo the store depth
      if (col_r[0]) begin
        idx_nxt = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
      end else begin
        idx_nxt = idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      idx_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      idx_r <= idx_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: captured input word
  // ---------------------------------------------------------------------
  logic             s1_valid_r;
  argb_t            s1_px_r;
  pos_t             s1_pos_r;
  logic [IDX_W-1:0] s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r  <= in_pixel_in;
      s1_pos_r <= pos_now;
      s1_idx_r <= idx_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: baked word, line store read data
  // ---------------------------------------------------------------------
  logic             s2_valid_r;
  argb_t            s2_baked_r;
  pos_t             s2_pos_r;
  logic [IDX_W-1:0] s2_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      s2_baked_r <= bake_en_r ? bake_px(s1_px_r, bg_r) : s1_px_r;
      s2_pos_r   <= s1_pos_r;
      s2_idx_r   <= s1_idx_r;
    end
  end

  // ---------------------------------------------------------------------
  // line store of even-row pair sums
  // ---------------------------------------------------------------------
  pair_t line_mem [LINE_DEPTH];
  pair_t mem_rd_r;
  logic  mem_we;
  pair_t pair;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s2_idx_r] <= pair;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      mem_rd_r <= line_mem[s1_idx_r];
    end
  end

  // last write, forwarded when it lands in the same cycle as the read
  logic             fwd_valid_r;
  logic [IDX_W-1:0] fwd_idx_r;
  pair_t            fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (mem_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fwd_idx_r  <= s2_idx_r;
      fwd_data_r <= pair;
    end
  end

  // ---------------------------------------------------------------------
  // pairing and box average
  // ---------------------------------------------------------------------
  argb_t hold_r;
  pair_t top;
  logic  have_pair;
  logic  dn_valid;
  logic  dn_last;
  argb_t dn_pixel;

  always_comb begin
    top       = (fwd_valid_r && fwd_idx_r == s2_idx_r) ? fwd_data_r : mem_rd_r;
    have_pair = s2_pos_r.col_odd || s2_pos_r.last_col;
    // even column on the right edge pairs with the background
    pair      = s2_pos_r.col_odd ? pair_sum(hold_r, s2_baked_r)
                                 : pair_sum(s2_baked_r, bg_r);
    dn_valid  = 1'b0;
    dn_pixel  = '0;
    mem_we    = 1'b0;
    if (have_pair) begin
      if (s2_pos_r.row_odd) begin
        dn_valid = 1'b1;
        dn_pixel = box_avg(top, pair);
      end else if (s2_pos_r.last_row) begin
        // odd bottom edge: lower row is background
        dn_valid = 1'b1;
        dn_pixel = box_avg(pair, pair_sum(bg_r, bg_r));
      end else begin
        mem_we = adv && s2_valid_r;
      end
    end
    dn_last = dn_valid && s2_pos_r.last_col && s2_pos_r.last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
    end else if (adv && s2_valid_r && !s2_pos_r.col_odd) begin
      hold_r <= s2_baked_r;
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      out_baked_pixel <= s2_baked_r;
      out_down_valid  <= dn_valid;
      out_down_pixel  <= dn_pixel;
      out_down_last   <= dn_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
